// ===== rtl/core/core_local_interruptor_defines.svh =====
// assertion macros used by the checker file of the core-local interruptor
`ifndef CORE_LOCAL_INTERRUPTOR_DEFINES_SVH
`define CORE_LOCAL_INTERRUPTOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CLINT_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("clint check failed");

// delayed implication, disabled during reset
`define CLINT_ASSERT_LATER(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> ##1 (cons)) \
        else $error("clint check failed");

`endif

// ===== rtl/core/clint_pkg.sv =====
// shared constants and types of the core-local interruptor
package clint_pkg;

    localparam int MAX_HARTS  = 8;
    localparam int HART_W     = (MAX_HARTS > 1) ? $clog2(MAX_HARTS) : 1;
    localparam int LINE_W     = 8;
    localparam int DATA_W     = 64;
    localparam int OFFSET_W   = 15;
    localparam int CNT_W      = 4;
    localparam int SOFT_IDX_W = OFFSET_W - 2;
    localparam int TMR_IDX_W  = OFFSET_W - 3;
    localparam int ADDR_W     = 3;
    localparam int PDATA_W    = 32;

    localparam logic [OFFSET_W-1:0]   MTIME_OFFSET  = 15'h7FF8;
    localparam logic [CNT_W-1:0]      HART_COUNT_RST = 4'd8;
    localparam logic [SOFT_IDX_W-1:0] SOFT_IDX_MAX  = SOFT_IDX_W'(MAX_HARTS);
    localparam logic [TMR_IDX_W-1:0]  TMR_IDX_MAX   = TMR_IDX_W'(MAX_HARTS);

    // register index carried on paddr[2]
    localparam logic CFG_IDX_HART_COUNT = 1'b0;

    localparam logic REGION_SOFT  = 1'b0;
    localparam logic REGION_TIMER = 1'b1;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } req_type_t;

endpackage

// ===== rtl/core/core_local_interruptor.sv =====
// core-local interruptor: per-hart software pending bits, timer compares and mtime
//
// usage:
//   an item (read, write or tick) is taken at a rising edge with start high and
//   busy low; busy stays low, so an item can be given in every cycle
//   each item gives one result on read_data, access_ok, soft_irq_lines and
//   timer_irq_lines, marked by done for exactly one cycle
//   the item sits in the input register, then the decode, state update and
//   mtime >= compare checks run on it and land in the result register;
//   throughput is one item per cycle
//   the irq lines show the state after the item's own update
//   hart_count is written over APB where paddr[2] is low; the user must write
//   it only while no item is in flight, which the block does not enforce; pready is always high
//   reset clears mtime and the pending bits, sets every compare to all ones
//   and hart_count to 8; results cannot be held off by the receiver, done
//   fires whether or not anyone is listening
module core_local_interruptor (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           req_type,
    input  logic                                 region,
    input  logic [clint_pkg::OFFSET_W-1:0]       offset,
    input  logic [clint_pkg::DATA_W-1:0]         write_data,
    output logic                                 done,
    output logic [clint_pkg::DATA_W-1:0]         read_data,
    output logic                                 access_ok,
    output logic [clint_pkg::LINE_W-1:0]         soft_irq_lines,
    output logic [clint_pkg::LINE_W-1:0]         timer_irq_lines,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [clint_pkg::ADDR_W-1:0]         paddr,
    input  logic [clint_pkg::PDATA_W-1:0]        pwdata,
    output logic [clint_pkg::PDATA_W-1:0]        prdata,
    output logic                                 pready
);

    // configuration
    logic [clint_pkg::CNT_W-1:0] hart_count_reg;

    // input register
    logic                              in_valid_reg;
    logic [1:0]                        in_req_reg;
    logic                              in_region_reg;
    logic [clint_pkg::OFFSET_W-1:0]    in_offset_reg;
    logic [clint_pkg::DATA_W-1:0]      in_data_reg;

    // block state
    logic [clint_pkg::DATA_W-1:0]      time_reg;
    logic [clint_pkg::DATA_W-1:0]      time_next;
    logic [clint_pkg::DATA_W-1:0]      cmp_reg  [clint_pkg::MAX_HARTS];
    logic [clint_pkg::DATA_W-1:0]      cmp_next [clint_pkg::MAX_HARTS];
    logic [clint_pkg::MAX_HARTS-1:0]   soft_reg;
    logic [clint_pkg::MAX_HARTS-1:0]   soft_next;

    // result register
    logic                              done_reg;
    logic [clint_pkg::DATA_W-1:0]      rdata_reg;
    logic [clint_pkg::DATA_W-1:0]      rdata_next;
    logic                              ok_reg;
    logic                              ok_next;
    logic [clint_pkg::LINE_W-1:0]      soft_line_reg;
    logic [clint_pkg::LINE_W-1:0]      soft_line_next;
    logic [clint_pkg::LINE_W-1:0]      tmr_line_reg;
    logic [clint_pkg::LINE_W-1:0]      tmr_line_next;

    // decode
    logic [clint_pkg::SOFT_IDX_W-1:0]  soft_idx;
    logic [clint_pkg::TMR_IDX_W-1:0]   tmr_idx;
    logic [clint_pkg::SOFT_IDX_W-1:0]  soft_cnt;
    logic [clint_pkg::TMR_IDX_W-1:0]   tmr_cnt;
    logic                              soft_hit;
    logic                              tmr_hit;
    logic                              is_mtime;
    logic [clint_pkg::HART_W-1:0]      soft_hart;
    logic [clint_pkg::HART_W-1:0]      tmr_hart;
    logic                              cfg_wr;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == clint_pkg::CFG_IDX_HART_COUNT)
                  ? {{(clint_pkg::PDATA_W - clint_pkg::CNT_W){1'b0}}, hart_count_reg}
                  : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hart_count_reg <= clint_pkg::HART_COUNT_RST;
        end
        else if (cfg_wr && (paddr[2] == clint_pkg::CFG_IDX_HART_COUNT))
        begin
            hart_count_reg <= pwdata[clint_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_req_reg    <= req_type;
            in_region_reg <= region;
            in_offset_reg <= offset;
            in_data_reg   <= write_data;
        end
    end

    assign soft_idx  = in_offset_reg[clint_pkg::OFFSET_W-1:2];
    assign tmr_idx   = in_offset_reg[clint_pkg::OFFSET_W-1:3];
    assign soft_cnt  = {{(clint_pkg::SOFT_IDX_W - clint_pkg::CNT_W){1'b0}}, hart_count_reg};
    assign tmr_cnt   = {{(clint_pkg::TMR_IDX_W - clint_pkg::CNT_W){1'b0}}, hart_count_reg};
    assign soft_hit  = (soft_idx < soft_cnt) && (soft_idx < clint_pkg::SOFT_IDX_MAX);
    assign tmr_hit   = (tmr_idx < tmr_cnt) && (tmr_idx < clint_pkg::TMR_IDX_MAX);
    assign is_mtime  = (in_offset_reg == clint_pkg::MTIME_OFFSET);
    assign soft_hart = soft_idx[clint_pkg::HART_W-1:0];
    assign tmr_hart  = tmr_idx[clint_pkg::HART_W-1:0];

    always_comb
    begin
        time_next  = time_reg;
        cmp_next   = cmp_reg;
        soft_next  = soft_reg;
        rdata_next = '0;
        ok_next    = 1'b0;
        if (in_valid_reg)
        begin
            case (in_req_reg)
                clint_pkg::REQ_TICK:
                begin
                    time_next = time_reg + 64'd1;
                    ok_next   = 1'b1;
                end
                clint_pkg::REQ_READ,
                clint_pkg::REQ_WRITE:
                begin
                    if (in_region_reg == clint_pkg::REGION_SOFT)
                    begin
                        if (soft_hit)
                        begin
                            ok_next = 1'b1;
                            if (in_req_reg == clint_pkg::REQ_WRITE)
                            begin
                                soft_next[soft_hart] = in_data_reg[0];
                            end
                            else
                            begin
                                rdata_next = {{(clint_pkg::DATA_W - 1){1'b0}},
                                              soft_reg[soft_hart]};
                            end
                        end
                    end
                    else if (is_mtime)
                    begin
                        // mtime wins over the hart decode
                        ok_next = 1'b1;
                        if (in_req_reg == clint_pkg::REQ_WRITE)
                        begin
                            time_next = in_data_reg;
                        end
                        else
                        begin
                            rdata_next = time_reg;
                        end
                    end
                    else if (tmr_hit)
                    begin
                        ok_next = 1'b1;
                        if (in_req_reg == clint_pkg::REQ_WRITE)
                        begin
                            cmp_next[tmr_hart] = in_data_reg;
                        end
                        else
                        begin
                            rdata_next = cmp_reg[tmr_hart];
                        end
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    // lines reflect the state after this item's update
    for (genvar i = 0; i < clint_pkg::LINE_W; i++)
    begin : g_line
        if (i < clint_pkg::MAX_HARTS)
        begin : g_hart
            logic present;
            assign present           = int'(hart_count_reg) > i;
            assign soft_line_next[i] = present && soft_next[i];
            assign tmr_line_next[i]  = present && (time_next >= cmp_next[i]);
        end
        else
        begin : g_none
            assign soft_line_next[i] = 1'b0;
            assign tmr_line_next[i]  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            soft_reg <= '0;
            for (int h = 0; h < clint_pkg::MAX_HARTS; h++)
            begin
                cmp_reg[h] <= '1;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            time_reg <= time_next;
            soft_reg <= soft_next;
            cmp_reg  <= cmp_next;
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            rdata_reg     <= rdata_next;
            ok_reg        <= ok_next;
            soft_line_reg <= soft_line_next;
            tmr_line_reg  <= tmr_line_next;
        end
    end

    assign done            = done_reg;
    assign read_data       = rdata_reg;
    assign access_ok       = ok_reg;
    assign soft_irq_lines  = soft_line_reg;
    assign timer_irq_lines = tmr_line_reg;

endmodule

// ===== rtl/core/clint_checker.sv =====
// port-level checks for the core-local interruptor, bound to the top level
`include "core_local_interruptor_defines.svh"

module clint_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [1:0]                    req_type,
    input logic                          done,
    input logic [clint_pkg::DATA_W-1:0]  read_data,
    input logic                          access_ok
);

    // every accepted item raises done once it has passed the input and result registers
    `CLINT_ASSERT_LATER(a_item_result, clk, rst_n, start && !busy, done)

    // a tick is always accepted and returns no data
    `CLINT_ASSERT_LATER(a_tick_ok, clk, rst_n,
        start && !busy && (req_type == clint_pkg::REQ_TICK),
        access_ok && (read_data == '0))

    // writes return no data
    `CLINT_ASSERT_LATER(a_write_zero, clk, rst_n,
        start && !busy && (req_type == clint_pkg::REQ_WRITE), read_data == '0)

    // a refused access never carries data
    `CLINT_ASSERT_IMPLY(a_refused_zero, clk, rst_n, done && !access_ok, read_data == '0)

endmodule

bind core_local_interruptor clint_checker u_clint_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .done      (done),
    .read_data (read_data),
    .access_ok (access_ok)
);
